// ===== sv/hsfd_pkg.sv =====
package hsfd_pkg;

  // reading type carried beside each frame
  typedef enum logic {
    KIND_TEMP = 1'b0,
    KIND_HUM  = 1'b1
  } kind_t;

  // crc-8, x^8+x^5+x^4+1, msb first, zero start value
  localparam logic [7:0] CRC_TAPS = 8'h31;

  localparam logic [7:0] TEMP_MASK = 8'hFC;
  localparam logic [7:0] HUM_MASK  = 8'hF0;

  // scale factors in hundredths per full-scale step, applied as raw*scale >> 16
  localparam logic [14:0] TEMP_SCALE = 15'd17572;
  localparam logic [14:0] HUM_SCALE  = 15'd12500;

  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
  localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;
  localparam logic signed [15:0] HUM_MAX     = 16'sd10000;

  // checked frame handed from the front part to the back part
  typedef struct packed {
    kind_t       kind;
    logic        failed;
    logic [15:0] raw;
  } item_t;

  // remainder of byte*x^8 modulo the crc polynomial
  function automatic logic [7:0] crc8_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_TAPS;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/humidity_sensor_frame_decode.sv =====
// frame decoder for a temperature / relative humidity sensor. each input beat
// carries one three-byte reading frame (high, low and crc-8 check byte) and a
// kind bit; each output beat carries the reading in hundredths (centidegrees
// c, or centipercent clamped to 0..10000), the check-failed flag and the kind.
// a frame whose crc-8 (x^8+x^5+x^4+1, zero start) remainder is nonzero gives
// value 0 with check_failed set. one beat is taken every clock cycle while the
// output does not stall; an input beat passes two front stages for the two
// byte-wise crc steps, the two-entry queue, one multiply stage and one
// offset / clamp stage. in steady flow the queue keeps one spare entry, so
// after the output stalls the input takes one more beat before its ready falls.
// reset clears only the valid flags, queue pointers and queue count.
module humidity_sensor_frame_decode
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // high_byte [7:0], low_byte [15:8], check_byte [23:16]
  input  logic [0:0]  s_axis_tuser,   // kind [0]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // value [14:0] (signed), zero pad [15]
  output logic [1:0]  m_axis_tuser    // check_failed [0], kind_out [1]
);

  // front to queue
  logic  f_valid;
  logic  f_ready;
  item_t f_item;

  // queue to back
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  logic signed [14:0] value;
  logic               check_failed;
  kind_t              kind_out;

  // crc check and status-bit masking
  hsfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (kind_t'(s_axis_tuser[0])),
    .in_high   (s_axis_tdata[7:0]),
    .in_low    (s_axis_tdata[15:8]),
    .in_check  (s_axis_tdata[23:16]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  // decouples the checker from output back pressure
  hsfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // scaling, offset and clamp; last stage is the output register
  hsfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (value),
    .out_failed (check_failed),
    .out_kind   (kind_out)
  );

  assign m_axis_tdata = {1'b0, value};
  assign m_axis_tuser = {kind_out, check_failed};

  // a bad frame always reads as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[14:0] == 15'd0)
    else $error("failed frame with nonzero value");

  // humidity stays within 0..10000
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      !m_axis_tdata[14] && (m_axis_tdata[14:0] <= HUM_MAX[14:0]))
    else $error("humidity out of range");

  // temperature never below the offset floor
  a_temp_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |->
      $signed(m_axis_tdata[14:0]) >= -$signed(TEMP_OFFSET[14:0]))
    else $error("temperature below floor");

endmodule

// ===== sv/hsfd_front.sv =====
module hsfd_front
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  kind_t       in_kind,
  input  logic [7:0]  in_high,
  input  logic [7:0]  in_low,
  input  logic [7:0]  in_check,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item
);

  // stage a: crc over the high byte
  logic       a_valid;
  kind_t      a_kind;
  logic [7:0] a_crc;
  logic [7:0] a_high;
  logic [7:0] a_low;
  logic [7:0] a_check;
  logic       a_ready;
  logic       b_ready;

  logic [7:0]  b_rem;
  logic [15:0] b_raw;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_kind  <= in_kind;
      a_crc   <= crc8_byte(in_high);
      a_high  <= in_high;
      a_low   <= in_low;
      a_check <= in_check;
    end
  end

  // stage b: fold in the low byte, compare with check byte, mask status bits
  always_comb begin
    b_rem = crc8_byte(a_crc ^ a_low) ^ a_check;
    if (a_kind == KIND_TEMP) begin
      b_raw = {a_high, a_low & TEMP_MASK};
    end else begin
      b_raw = {a_high, a_low & HUM_MASK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_item.kind   <= a_kind;
      out_item.failed <= (b_rem != 8'h00);
      out_item.raw    <= b_raw;
    end
  end

endmodule

// ===== sv/hsfd_queue.sv =====
module hsfd_queue
  import hsfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== sv/hsfd_back.sv =====
module hsfd_back
  import hsfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  item_t              in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_value,
  output logic               out_failed,
  output kind_t              out_kind
);

  // stage p: scale multiply
  logic        p_valid;
  kind_t       p_kind;
  logic        p_failed;
  logic [14:0] p_scaled;
  logic        p_ready;
  logic        o_ready;

  logic [30:0] product;
  logic signed [15:0] diff;
  logic signed [14:0] result;

  assign o_ready  = !out_valid || out_ready;
  assign p_ready  = !p_valid || o_ready;
  assign in_ready = p_ready;

  always_comb begin
    if (in_item.kind == KIND_TEMP) begin
      product = 31'(in_item.raw) * 31'(TEMP_SCALE);
    end else begin
      product = 31'(in_item.raw) * 31'(HUM_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      p_kind   <= in_item.kind;
      p_failed <= in_item.failed;
      p_scaled <= product[30:16];
    end
  end

  // offset, humidity clamp, zero on a bad frame
  always_comb begin
    if (p_kind == KIND_TEMP) begin
      diff   = $signed({1'b0, p_scaled}) - TEMP_OFFSET;
      result = diff[14:0];
    end else begin
      diff = $signed({1'b0, p_scaled}) - HUM_OFFSET;
      if (diff < 16'sd0) begin
        result = '0;
      end else if (diff > HUM_MAX) begin
        result = HUM_MAX[14:0];
      end else begin
        result = diff[14:0];
      end
    end
    if (p_failed) begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && p_valid) begin
      out_value  <= result;
      out_failed <= p_failed;
      out_kind   <= p_kind;
    end
  end

endmodule

// ===== tb/tb_humidity_sensor_frame_decode.sv =====
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decode;
  import hsfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEM_COUNT  = 1450;
  localparam logic [7:0]  POLY_LOW    = 8'h31;      // x^8+x^5+x^4+1 without the x^8 term
  localparam logic [7:0]  TEMP_KEEP   = 8'hFC;
  localparam logic [7:0]  HUM_KEEP    = 8'hF0;
  localparam int unsigned TEMP_GAIN   = 17572;
  localparam int unsigned HUM_GAIN    = 12500;
  localparam int          TEMP_SHIFT  = 4685;
  localparam int          HUM_SHIFT   = 600;
  localparam int          HUM_TOP     = 10000;

  typedef struct {
    logic signed [14:0] value;
    logic               failed;
    kind_t              kind;
  } reading_t;

  // expected readings in arrival order, plus the mismatch tally
  class reading_scoreboard;
    reading_t    readings[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // msb-first crc-8 of the two data bytes, zero start value
    static function logic [7:0] frame_crc(logic [15:0] data);
      logic [7:0] r;
      logic       fb;
      r = 8'h00;
      for (int i = 15; i >= 0; i--) begin
        fb = r[7] ^ data[i];
        r  = {r[6:0], 1'b0} ^ (fb ? POLY_LOW : 8'h00);
      end
      return r;
    endfunction

    static function reading_t decode(kind_t kind, logic [7:0] hi, logic [7:0] lo,
                                     logic [7:0] chk);
      reading_t    r;
      logic [15:0] raw;
      int unsigned prod;
      int          v;
      r.kind   = kind;
      r.failed = (frame_crc({hi, lo}) != chk);
      r.value  = '0;
      if (!r.failed) begin
        if (kind == KIND_TEMP) begin
          raw  = {hi, lo & TEMP_KEEP};
          prod = raw * TEMP_GAIN;
          v    = int'(prod >> 16) - TEMP_SHIFT;
        end else begin
          raw  = {hi, lo & HUM_KEEP};
          prod = raw * HUM_GAIN;
          v    = int'(prod >> 16) - HUM_SHIFT;
          if (v < 0) v = 0;
          else if (v > HUM_TOP) v = HUM_TOP;
        end
        r.value = v[14:0];
      end
      return r;
    endfunction

    function void note_frame(kind_t kind, logic [7:0] hi, logic [7:0] lo, logic [7:0] chk);
      readings.push_back(decode(kind, hi, lo, chk));
    endfunction

    function void check_reading(logic signed [14:0] value, logic failed, kind_t kind);
      reading_t want;
      if (readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: value %0d check_failed %0b kind %0d",
                   value, failed, kind);
        return;
      end
      want = readings.pop_front();
      if (value !== want.value || failed !== want.failed || kind !== want.kind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %0d/%0d check_failed %0b/%0b kind %0d/%0d (exp/act)",
                   want.value, value, want.failed, failed, want.kind, kind);
      end
    endfunction

    function int unsigned pending();
      return readings.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // high_byte [7:0], low_byte [15:8], check_byte [23:16]
  logic [0:0]  s_axis_tuser = '0;   // kind [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // value [14:0] (signed), zero pad [15]
  logic [1:0]  m_axis_tuser;        // check_failed [0], kind_out [1]

  reading_scoreboard sb = new();
  bit                sender_gaps = 1'b1;
  int unsigned       cycles = 0;

  humidity_sensor_frame_decode dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // offer one frame and wait for its beat to be taken
  task automatic send_frame(kind_t kind, logic [7:0] hi, logic [7:0] lo, logic [7:0] chk);
    if (sender_gaps) begin
      while ($urandom_range(0, 99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {chk, lo, hi};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_frame(kind, hi, lo, chk);
  endtask

  // frame with a correct check byte, optionally with bits flipped in it
  task automatic send_checked(kind_t kind, logic [7:0] hi, logic [7:0] lo,
                              logic [7:0] flip);
    send_frame(kind, hi, lo, reading_scoreboard::frame_crc({hi, lo}) ^ flip);
  endtask

  // output side: random backpressure, one long hold, a quiet window
  initial begin
    int unsigned seen;
    int unsigned hold;
    seen = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_reading(m_axis_tdata[14:0], m_axis_tuser[0], kind_t'(m_axis_tuser[1]));
        seen++;
        // long hold so the pipeline and queue fill and the input stalls
        if (seen == 300) hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (seen >= 600 && seen < 900) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  initial begin
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] flip;
    kind_t      kind;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, clamp edges, status bits, bad check bytes
    send_checked(KIND_TEMP, 8'h00, 8'h00, 8'h00);   // coldest reading
    send_checked(KIND_TEMP, 8'hFF, 8'hFC, 8'h00);   // hottest reading
    send_checked(KIND_TEMP, 8'hFF, 8'hFF, 8'h00);   // status bits ignored
    send_checked(KIND_TEMP, 8'h66, 8'h4F, 8'h00);
    send_checked(KIND_HUM,  8'h00, 8'h00, 8'h00);   // clamps to zero
    send_checked(KIND_HUM,  8'h0C, 8'h40, 8'h00);   // just below zero
    send_checked(KIND_HUM,  8'h0C, 8'h50, 8'h00);   // just above zero
    send_checked(KIND_HUM,  8'hD9, 8'h10, 8'h00);   // just below full scale
    send_checked(KIND_HUM,  8'hD9, 8'h20, 8'h00);   // clamps to full scale
    send_checked(KIND_HUM,  8'hFF, 8'hFF, 8'h00);
    send_checked(KIND_HUM,  8'h7C, 8'h8F, 8'h00);
    send_checked(KIND_TEMP, 8'h12, 8'h34, 8'h01);   // bad check, low bit
    send_checked(KIND_HUM,  8'h56, 8'h78, 8'h80);   // bad check, high bit
    send_checked(KIND_HUM,  8'hFF, 8'hFF, 8'hFF);
    send_frame(KIND_TEMP, 8'hFF, 8'hFF, 8'h00);
    send_frame(KIND_HUM,  8'h00, 8'h00, 8'hFF);
    send_frame(KIND_TEMP, 8'hA5, 8'h5A, 8'hFF);

    // random: mostly well-formed frames, some with damaged check bytes
    for (int unsigned n = 0; n < ITEM_COUNT; n++) begin
      sender_gaps = !(n >= 600 && n < 900);
      if (n == 1100) begin
        // drain completely before carrying on
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      kind = kind_t'($urandom_range(0, 1));
      hi   = 8'($urandom_range(0, 255));
      lo   = 8'($urandom_range(0, 255));
      flip = 8'h00;
      if ($urandom_range(0, 99) < 15) flip = 8'($urandom_range(1, 255));
      send_checked(kind, hi, lo, flip);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
